>>> rtl/bdcb_pkg.sv
// Package for the centre-weighted block downscaler.
// Field widths, register indexes, sequencer states and the lane control group.
`default_nettype none

package bdcb_pkg;

  localparam int PIX_W      = 8;
  localparam int FACTOR_W   = 5;
  localparam int BLEND_W    = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_LANES  = 4;
  // quotient is never above 255, so eight restoring steps cover it
  localparam int DIV_STEPS  = 8;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLEND    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ON = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_COEF0,
    ST_COEF1,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic acc;     // pixel request taken this cycle
    logic centre;  // that pixel is the block centre
    logic clr;     // restart the block
    logic mul;     // form the two weighted products
    logic load;    // add products into the remainder
    logic step;    // one restoring division step
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> rtl/bdcb_if.sv
// Channel interfaces of the downscaler: source pixels, target pixels, config writes.
// Depends on bdcb_pkg.
`default_nettype none

interface bdcb_pix_in_if;
  logic                       valid;
  logic                       ready;
  logic [bdcb_pkg::PIX_W-1:0] chan_blue;
  logic [bdcb_pkg::PIX_W-1:0] chan_green;
  logic [bdcb_pkg::PIX_W-1:0] chan_red;
  logic [bdcb_pkg::PIX_W-1:0] chan_alpha;

  modport source (output valid, chan_blue, chan_green, chan_red, chan_alpha, input ready);
  modport sink   (input valid, chan_blue, chan_green, chan_red, chan_alpha, output ready);
endinterface

interface bdcb_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdcb_pkg::PIX_W-1:0] out_blue;
  logic [bdcb_pkg::PIX_W-1:0] out_green;
  logic [bdcb_pkg::PIX_W-1:0] out_red;
  logic [bdcb_pkg::PIX_W-1:0] out_alpha;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

interface bdcb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bdcb_pkg::CFG_IDX_W-1:0]  index;
  logic [bdcb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/block_downscale_center_blend.sv
// Top level of the centre-weighted block downscaler: config registers, block
// position, coefficient sequencer, four lanes and the merging stage.
// Depends on bdcb_pkg, bdcb_if, bdcb_lane, bdcb_merge.
//
//   channel  direction  payload
//   pix_i    in         chan_blue, chan_green, chan_red, chan_alpha
//   pix_o    out        out_blue, out_green, out_red, out_alpha
//   cfg_i    in         index, data (factor_x, factor_y, blend, alpha_on)
//
// A source pixel is taken only in the accumulate state. After the last pixel of a
// block the sequencer runs two coefficient steps, one product step, one load step,
// the eight steps of the restoring divider in each lane and one hand-over step.
// The target pixel then waits in the output register while the next block is
// taken in; a stalled output only holds the hand-over state. Reset restores the
// register defaults and an empty block; config writes are always accepted.
`default_nettype none

module block_downscale_center_blend #(
  parameter int MAX_FACTOR = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bdcb_pix_in_if.sink     pix_i,
  bdcb_pix_out_if.source  pix_o,
  bdcb_cfg_if.sink        cfg_i
);

  localparam int EF_MAX = (MAX_FACTOR < 31) ? MAX_FACTOR : 31;
  localparam int EF_W   = $clog2(EF_MAX + 1);
  localparam int DMAX   = EF_MAX * EF_MAX;
  localparam int D_W    = $clog2(DMAX + 1);
  localparam int SUM_W  = $clog2(255 * DMAX + 1);
  localparam int K1_W   = $clog2(((1 << bdcb_pkg::BLEND_W) - 1) * DMAX + 1);
  localparam int DEN_W  = $clog2(DMAX * DMAX + 1);
  localparam int NUM_W  = $clog2(255 * DMAX * DMAX + 1);

  logic [bdcb_pkg::FACTOR_W-1:0] fx_q, fy_q;
  logic [bdcb_pkg::BLEND_W-1:0]  blend_q;
  logic                          alpha_q;
  logic [EF_W-1:0]               fx_e, fy_e, col_q, row_q;
  logic [D_W-1:0]                d_q, k2_q;
  logic [K1_W-1:0]               k1_q, b_w, dm1_w;
  logic [DEN_W-1:0]              den_q;
  logic [NUM_W-1:0]              dv_q;
  logic [bdcb_pkg::STEP_W-1:0]   step_q;
  bdcb_pkg::state_e              state_q, state_d;
  bdcb_pkg::lane_ctl_t           ctl;
  logic                          in_acc, cfg_acc, factor_wr, last_col, last_px;
  logic                          blended, merge_free, merge_load;
  logic [bdcb_pkg::NUM_LANES-1:0][bdcb_pkg::PIX_W-1:0] px, quo;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_comb begin
    factor_wr = 1'b0;
    if (cfg_acc) begin
      unique case (cfg_i.index) inside
        bdcb_pkg::REG_FACTOR_X, bdcb_pkg::REG_FACTOR_Y: factor_wr = 1'b1;
        default:                                        factor_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q    <= bdcb_pkg::FACTOR_W'(2);
      fy_q    <= bdcb_pkg::FACTOR_W'(2);
      blend_q <= '0;
      alpha_q <= 1'b1;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        bdcb_pkg::REG_FACTOR_X: fx_q    <= cfg_i.data[bdcb_pkg::FACTOR_W-1:0];
        bdcb_pkg::REG_FACTOR_Y: fy_q    <= cfg_i.data[bdcb_pkg::FACTOR_W-1:0];
        bdcb_pkg::REG_BLEND:    blend_q <= cfg_i.data[bdcb_pkg::BLEND_W-1:0];
        bdcb_pkg::REG_ALPHA_ON: alpha_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the limit as the limit
  assign fx_e = (fx_q == '0) ? EF_W'(1) :
                (fx_q > bdcb_pkg::FACTOR_W'(EF_MAX)) ? EF_W'(EF_MAX) : EF_W'(fx_q);
  assign fy_e = (fy_q == '0) ? EF_W'(1) :
                (fy_q > bdcb_pkg::FACTOR_W'(EF_MAX)) ? EF_W'(EF_MAX) : EF_W'(fy_q);

  // ---------------- block position ----------------
  assign in_acc   = pix_i.valid && pix_i.ready;
  assign last_col = (col_q + EF_W'(1)) == fx_e;
  assign last_px  = last_col && ((row_q + EF_W'(1)) == fy_e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (factor_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_px ? '0 : row_q + EF_W'(1);
      end else begin
        col_q <= col_q + EF_W'(1);
      end
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdcb_pkg::ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdcb_pkg::ST_ACC:   if (in_acc && last_px) state_d = bdcb_pkg::ST_COEF0;
      bdcb_pkg::ST_COEF0: state_d = bdcb_pkg::ST_COEF1;
      bdcb_pkg::ST_COEF1: state_d = bdcb_pkg::ST_MUL;
      bdcb_pkg::ST_MUL:   state_d = bdcb_pkg::ST_LOAD;
      bdcb_pkg::ST_LOAD:  state_d = bdcb_pkg::ST_DIV;
      bdcb_pkg::ST_DIV: begin
        if (step_q == bdcb_pkg::STEP_W'(bdcb_pkg::DIV_STEPS - 1)) state_d = bdcb_pkg::ST_OUT;
      end
      bdcb_pkg::ST_OUT:   if (merge_free) state_d = bdcb_pkg::ST_ACC;
      default:            state_d = bdcb_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    pix_i.ready = (state_q == bdcb_pkg::ST_ACC);
    ctl.acc     = in_acc;
    ctl.centre  = (col_q == ((fx_e - EF_W'(1)) >> 1)) && (row_q == ((fy_e - EF_W'(1)) >> 1));
    ctl.clr     = factor_wr;
    ctl.mul     = (state_q == bdcb_pkg::ST_MUL);
    ctl.load    = (state_q == bdcb_pkg::ST_LOAD);
    ctl.step    = (state_q == bdcb_pkg::ST_DIV);
    merge_load  = (state_q == bdcb_pkg::ST_OUT) && merge_free;
  end

  // ---------------- shared coefficients ----------------
  // plain average uses unit weights over D, blending weights over D*(D-1)
  assign blended = (blend_q > bdcb_pkg::BLEND_W'(1)) && (d_q > D_W'(1));
  assign b_w     = (K1_W'(blend_q) < K1_W'(d_q)) ? K1_W'(blend_q) : K1_W'(d_q);
  assign dm1_w   = K1_W'(d_q - D_W'(1));

  always_ff @(posedge clk_i) begin
    if (state_q == bdcb_pkg::ST_COEF0) begin
      d_q <= D_W'(D_W'(fx_e) * D_W'(fy_e));
    end
    if (state_q == bdcb_pkg::ST_COEF1) begin
      if (blended) begin
        k1_q  <= K1_W'(b_w * dm1_w);
        k2_q  <= D_W'(K1_W'(d_q) - b_w);
        den_q <= DEN_W'(DEN_W'(d_q) * DEN_W'(dm1_w));
      end else begin
        k1_q  <= K1_W'(1);
        k2_q  <= D_W'(1);
        den_q <= DEN_W'(d_q);
      end
    end
    if (state_q == bdcb_pkg::ST_LOAD) begin
      dv_q   <= NUM_W'(den_q) << (bdcb_pkg::DIV_STEPS - 1);
      step_q <= '0;
    end else if (state_q == bdcb_pkg::ST_DIV) begin
      dv_q   <= dv_q >> 1;
      step_q <= step_q + bdcb_pkg::STEP_W'(1);
    end
  end

  // ---------------- lanes ----------------
  assign px = {pix_i.chan_alpha, pix_i.chan_red, pix_i.chan_green, pix_i.chan_blue};

  for (genvar g = 0; g < bdcb_pkg::NUM_LANES; g++) begin : g_lane
    bdcb_lane #(
      .SUM_W (SUM_W),
      .K1_W  (K1_W),
      .K2_W  (D_W),
      .NUM_W (NUM_W)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .px_i   (px[g]),
      .k1_i   (k1_q),
      .k2_i   (k2_q),
      .dv_i   (dv_q),
      .q_o    (quo[g])
    );
  end

  bdcb_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (merge_load),
    .alpha_on_i (alpha_q),
    .q_i        (quo),
    .free_o     (merge_free),
    .pix_o      (pix_o)
  );

  // ---------------- assertions ----------------
  a_pos_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdcb_pkg::ST_ACC) |-> (col_q < fx_e) && (row_q < fy_e))
    else $error("block position outside the block");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pix_o.valid) |-> $past(state_q == bdcb_pkg::ST_OUT))
    else $error("target pixel raised outside hand-over");

  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdcb_pkg::ST_OUT && merge_free) |=> (state_q == bdcb_pkg::ST_ACC) && pix_o.valid)
    else $error("hand-over did not fill the output register");

endmodule

`default_nettype wire

>>> rtl/bdcb_lane.sv
// One channel lane: centre capture, sum of the other pixels, weighted products
// and a restoring divider. Depends on bdcb_pkg.
`default_nettype none

module bdcb_lane #(
  parameter int SUM_W = 16,
  parameter int K1_W  = 17,
  parameter int K2_W  = 9,
  parameter int NUM_W = 25
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bdcb_pkg::lane_ctl_t        ctl_i,
  input  wire logic [bdcb_pkg::PIX_W-1:0] px_i,
  input  wire logic [K1_W-1:0]            k1_i,
  input  wire logic [K2_W-1:0]            k2_i,
  input  wire logic [NUM_W-1:0]           dv_i,
  output logic      [bdcb_pkg::PIX_W-1:0] q_o
);

  logic [bdcb_pkg::PIX_W-1:0] centre_q;
  logic [SUM_W-1:0]           sum_q;
  logic [NUM_W-1:0]           p1_q, p2_q, rem_q;
  logic [bdcb_pkg::PIX_W-1:0] quo_q;
  logic                       fits;

  assign fits = (rem_q >= dv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
      sum_q    <= '0;
    end else if (ctl_i.clr || ctl_i.mul) begin
      centre_q <= '0;
      sum_q    <= '0;
    end else if (ctl_i.acc) begin
      if (ctl_i.centre) begin
        centre_q <= px_i;
      end else begin
        sum_q <= sum_q + SUM_W'(px_i);
      end
    end
  end

  // products and quotient are payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      p1_q <= NUM_W'(NUM_W'(centre_q) * NUM_W'(k1_i));
      p2_q <= NUM_W'(NUM_W'(sum_q) * NUM_W'(k2_i));
    end
    if (ctl_i.load) begin
      rem_q <= p1_q + p2_q;
      quo_q <= '0;
    end else if (ctl_i.step) begin
      if (fits) begin
        rem_q <= rem_q - dv_i;
      end
      quo_q <= {quo_q[bdcb_pkg::PIX_W-2:0], fits};
    end
  end

  // numerator never exceeds 255 times the divisor, so the quotient is already saturated
  assign q_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/bdcb_merge.sv
// Merging stage: gathers the lane quotients into one target pixel and holds it
// in the output register. Depends on bdcb_pkg and bdcb_if.
`default_nettype none

module bdcb_merge (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              load_i,
  input  wire logic                                              alpha_on_i,
  input  wire logic [bdcb_pkg::NUM_LANES-1:0][bdcb_pkg::PIX_W-1:0] q_i,
  output logic                                                   free_o,
  bdcb_pix_out_if.source                                         pix_o
);

  logic valid_q;

  assign free_o = !valid_q || pix_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pix_o.out_blue  <= q_i[0];
      pix_o.out_green <= q_i[1];
      pix_o.out_red   <= q_i[2];
      pix_o.out_alpha <= alpha_on_i ? q_i[3] : '0;
    end
  end

  assign pix_o.valid = valid_q;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for block_downscale_center_blend: drives source pixels and
// register writes, predicts each target pixel and compares it field by field.
// Depends on bdcb_pkg, bdcb_if and the RTL of the block.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FACTOR   = 16;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_PCT     = 8;
  localparam int CHAN_MAX     = (1 << bdcb_pkg::PIX_W) - 1;
  localparam logic [bdcb_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = bdcb_pkg::REG_ALPHA_ON + 1'b1;

  typedef struct packed {
    logic [bdcb_pkg::PIX_W-1:0] alpha;
    logic [bdcb_pkg::PIX_W-1:0] red;
    logic [bdcb_pkg::PIX_W-1:0] green;
    logic [bdcb_pkg::PIX_W-1:0] blue;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  bdcb_pix_in_if  pix_if ();
  bdcb_pix_out_if res_if ();
  bdcb_cfg_if     cfg_if ();

  block_downscale_center_blend #(
    .MAX_FACTOR(MAX_FACTOR)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .pix_o (res_if),
    .cfg_i (cfg_if)
  );

  // shadow registers and block state of the downscaler
  logic [bdcb_pkg::FACTOR_W-1:0] fx_reg;
  logic [bdcb_pkg::FACTOR_W-1:0] fy_reg;
  logic [bdcb_pkg::BLEND_W-1:0]  blend_reg;
  logic                          alpha_reg;
  int unsigned                   blk_col;
  int unsigned                   blk_row;
  int unsigned                   chan_sum [bdcb_pkg::NUM_LANES];
  pixel_t                        centre_px;

  pixel_t target_pixels_q [$];
  pixel_t got_px;
  pixel_t want_px;
  string  chan_name [bdcb_pkg::NUM_LANES] = '{"blue", "green", "red", "alpha"};

  int mismatch_count = 0;
  int pixels_sent    = 0;
  int sink_hold      = 0;
  int cycle_count    = 0;
  bit idle_on        = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("block_downscale_center_blend regression: fail");
      $finish;
    end
  end

  function automatic int unsigned factor_eff(input logic [bdcb_pkg::FACTOR_W-1:0] f);
    if (f == '0) return 1;
    if (f > MAX_FACTOR) return MAX_FACTOR;
    return f;
  endfunction

  function automatic void clear_block();
    blk_col   = 0;
    blk_row   = 0;
    centre_px = '0;
    for (int c = 0; c < bdcb_pkg::NUM_LANES; c++) chan_sum[c] = 0;
  endfunction

  function automatic void apply_reg(input logic [bdcb_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bdcb_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bdcb_pkg::REG_FACTOR_X: begin
        fx_reg = val[bdcb_pkg::FACTOR_W-1:0];
        clear_block();
      end
      bdcb_pkg::REG_FACTOR_Y: begin
        fy_reg = val[bdcb_pkg::FACTOR_W-1:0];
        clear_block();
      end
      bdcb_pkg::REG_BLEND:    blend_reg = val[bdcb_pkg::BLEND_W-1:0];
      bdcb_pkg::REG_ALPHA_ON: alpha_reg = val[0];
      default: ;
    endcase
  endfunction

  // Accumulates one source pixel; on the last pixel of a block queues the target.
  function automatic void downscale_pixel(input pixel_t p);
    int unsigned                fx;
    int unsigned                fy;
    int unsigned                d;
    longint unsigned            b;
    longint unsigned            num;
    longint unsigned            q;
    logic [bdcb_pkg::PIX_W-1:0] ctr;
    pixel_t                     res;
    fx = factor_eff(fx_reg);
    fy = factor_eff(fy_reg);
    d  = fx * fy;
    if (blk_col >= fx) blk_col = 0;
    if (blk_row >= fy) blk_row = 0;
    if (blk_col == (fx - 1) / 2 && blk_row == (fy - 1) / 2) centre_px = p;
    else for (int c = 0; c < bdcb_pkg::NUM_LANES; c++)
      chan_sum[c] += p[bdcb_pkg::PIX_W*c +: bdcb_pkg::PIX_W];
    blk_col++;
    if (blk_col < fx) return;
    blk_col = 0;
    blk_row++;
    if (blk_row < fy) return;
    blk_row = 0;
    for (int c = 0; c < bdcb_pkg::NUM_LANES; c++) begin
      ctr = centre_px[bdcb_pkg::PIX_W*c +: bdcb_pkg::PIX_W];
      if (d == 1) begin
        q = ctr;
      end else if (blend_reg > 1) begin
        b   = (blend_reg < d) ? blend_reg : d;
        num = longint'(ctr) * b * (d - 1) + longint'(chan_sum[c]) * (d - b);
        q   = num / (longint'(d) * (d - 1));
      end else begin
        q = (longint'(ctr) + chan_sum[c]) / d;
      end
      if (q > CHAN_MAX) q = CHAN_MAX;
      res[bdcb_pkg::PIX_W*c +: bdcb_pkg::PIX_W] = q[bdcb_pkg::PIX_W-1:0];
    end
    if (!alpha_reg) res.alpha = '0;
    target_pixels_q.push_back(res);
    clear_block();
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_px = {res_if.out_alpha, res_if.out_red, res_if.out_green, res_if.out_blue};
      if (target_pixels_q.size() == 0) begin
        $display("%0t: target pixel %h with none outstanding", $time, got_px);
        mismatch_count++;
      end else begin
        want_px = target_pixels_q.pop_front();
        for (int c = 0; c < bdcb_pkg::NUM_LANES; c++) begin
          if (got_px[bdcb_pkg::PIX_W*c +: bdcb_pkg::PIX_W] !==
              want_px[bdcb_pkg::PIX_W*c +: bdcb_pkg::PIX_W]) begin
            $display("%0t: out_%s expected %0d got %0d", $time, chan_name[c],
                     want_px[bdcb_pkg::PIX_W*c +: bdcb_pkg::PIX_W],
                     got_px[bdcb_pkg::PIX_W*c +: bdcb_pkg::PIX_W]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver: random idling plus a counted long hold-off
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        res_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        res_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_pixel(input pixel_t p);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid      <= 1'b1;
    pix_if.chan_blue  <= p.blue;
    pix_if.chan_green <= p.green;
    pix_if.chan_red   <= p.red;
    pix_if.chan_alpha <= p.alpha;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    downscale_pixel(p);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [bdcb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdcb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // stop offering, wait for every outstanding target, then let the sequencer settle
  task automatic wait_drained();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (target_pixels_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = pixel_t'($urandom);
    if ($urandom_range(7) == 0)
      for (int c = 0; c < bdcb_pkg::NUM_LANES; c++)
        p[bdcb_pkg::PIX_W*c +: bdcb_pkg::PIX_W] = $urandom_range(1) ? '1 : '0;
    return p;
  endfunction

  task automatic send_blocks(input int n_blocks, input bit ragged_tail);
    int unsigned d;
    int unsigned n;
    d = factor_eff(fx_reg) * factor_eff(fy_reg);
    n = n_blocks * d;
    if (ragged_tail && d > 1) n += $urandom_range(d - 1, 1);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic random_config(input bit with_factors);
    logic [bdcb_pkg::CFG_DATA_W-1:0] word;
    bit                              wide;
    wide = ($urandom_range(15) >= 13);
    if (with_factors) begin
      word = bdcb_pkg::CFG_DATA_W'($urandom);
      word[bdcb_pkg::FACTOR_W-1:0] = wide ? bdcb_pkg::FACTOR_W'($urandom) :
                                            bdcb_pkg::FACTOR_W'($urandom_range(4, 1));
      write_reg(bdcb_pkg::REG_FACTOR_X, word);
      word = bdcb_pkg::CFG_DATA_W'($urandom);
      word[bdcb_pkg::FACTOR_W-1:0] = wide ? bdcb_pkg::FACTOR_W'($urandom) :
                                            bdcb_pkg::FACTOR_W'($urandom_range(4, 1));
      write_reg(bdcb_pkg::REG_FACTOR_Y, word);
    end
    word = bdcb_pkg::CFG_DATA_W'($urandom);
    case ($urandom_range(5))
      0: word[bdcb_pkg::BLEND_W-1:0] = '0;
      1: word[bdcb_pkg::BLEND_W-1:0] = bdcb_pkg::BLEND_W'(1);
      2: word[bdcb_pkg::BLEND_W-1:0] = bdcb_pkg::BLEND_W'(2);
      3: word[bdcb_pkg::BLEND_W-1:0] = bdcb_pkg::BLEND_W'(256);
      4: word[bdcb_pkg::BLEND_W-1:0] = '1;
      default: word[bdcb_pkg::BLEND_W-1:0] = bdcb_pkg::BLEND_W'($urandom_range(20));
    endcase
    write_reg(bdcb_pkg::REG_BLEND, word);
    write_reg(bdcb_pkg::REG_ALPHA_ON, bdcb_pkg::CFG_DATA_W'($urandom));
    if ($urandom_range(3) == 0)
      write_reg(bdcb_pkg::CFG_IDX_W'($urandom_range((1 << bdcb_pkg::CFG_IDX_W) - 1,
                                                    REG_FIRST_UNUSED)),
                bdcb_pkg::CFG_DATA_W'($urandom));
  endtask

  // reset values: 2x2 average with alpha kept, channel extremes
  task automatic test_reset_defaults();
    send_pixel(pixel_t'(32'hFFFF_FFFF));
    send_pixel(pixel_t'(32'h0000_0000));
    send_pixel(pixel_t'(32'hA5A5_A5A5));
    send_pixel(pixel_t'(32'h5A5A_5A5A));
    wait_drained();
  endtask

  // zero factor acts as one: 1x1 block passes the pixel through
  task automatic test_single_pixel();
    write_reg(bdcb_pkg::REG_FACTOR_X, 16'hFFE0);
    write_reg(bdcb_pkg::REG_FACTOR_Y, 16'h0001);
    send_pixel(pixel_t'(32'hFF00_7F80));
    wait_drained();
  endtask

  // factor above the maximum clamps to 16; blend above D; alpha off
  task automatic test_oversize_factor();
    write_reg(bdcb_pkg::REG_FACTOR_X, 16'hFFF4);
    write_reg(bdcb_pkg::REG_FACTOR_Y, 16'h0020);
    write_reg(bdcb_pkg::REG_BLEND, 16'hFFFF);
    write_reg(bdcb_pkg::REG_ALPHA_ON, 16'hFFFE);
    send_blocks(1, 1'b0);
    wait_drained();
  endtask

  // factor write drops a partial block; other writes leave it alone
  task automatic test_block_restart();
    write_reg(bdcb_pkg::REG_FACTOR_X, 16'd3);
    write_reg(bdcb_pkg::REG_FACTOR_Y, 16'd1);
    write_reg(bdcb_pkg::REG_BLEND, 16'd0);
    write_reg(bdcb_pkg::REG_ALPHA_ON, 16'd1);
    send_pixel(pixel_t'(32'h1122_3344));
    wait_drained();
    write_reg(bdcb_pkg::REG_FACTOR_X, 16'd2);
    send_pixel(pixel_t'(32'hC0FF_EE01));
    wait_drained();
    write_reg(bdcb_pkg::REG_BLEND, 16'd2);
    write_reg(REG_FIRST_UNUSED, 16'hFFFF);
    write_reg(bdcb_pkg::REG_ALPHA_ON, 16'd0);
    send_pixel(pixel_t'(32'hFFFF_FFFF));
    wait_drained();
  endtask

  task automatic test_random_blocks();
    int  goal;
    bit  first;
    bit  big;
    goal  = pixels_sent + RANDOM_ITEMS;
    first = 1'b1;
    while (pixels_sent < goal) begin
      random_config(first || $urandom_range(3) != 0);
      first = 1'b0;
      big   = factor_eff(fx_reg) * factor_eff(fy_reg) > 16;
      send_blocks(big ? 1 : $urandom_range(12, 1), $urandom_range(3) == 0);
      wait_drained();
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    write_reg(bdcb_pkg::REG_FACTOR_X, 16'd2);
    write_reg(bdcb_pkg::REG_FACTOR_Y, 16'd2);
    write_reg(bdcb_pkg::REG_BLEND, 16'd3);
    send_blocks(50, 1'b0);
    wait_drained();
    idle_on = 1'b1;
  endtask

  // receiver holds off long enough for the block to fill and refuse requests
  task automatic test_output_stall();
    write_reg(bdcb_pkg::REG_FACTOR_X, 16'd2);
    write_reg(bdcb_pkg::REG_FACTOR_Y, 16'd1);
    write_reg(bdcb_pkg::REG_ALPHA_ON, 16'd1);
    sink_hold = 400;
    send_blocks(40, 1'b0);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    write_reg(bdcb_pkg::REG_FACTOR_X, 16'd3);
    write_reg(bdcb_pkg::REG_FACTOR_Y, 16'd3);
    send_blocks(3, 1'b0);
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (target_pixels_q.size() != 0) @(posedge clk_i);
    send_blocks(3, 1'b0);
    wait_drained();
  endtask

  initial begin
    rst_ni            = 1'b0;
    pix_if.valid      = 1'b0;
    pix_if.chan_blue  = '0;
    pix_if.chan_green = '0;
    pix_if.chan_red   = '0;
    pix_if.chan_alpha = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    fx_reg            = bdcb_pkg::FACTOR_W'(2);
    fy_reg            = bdcb_pkg::FACTOR_W'(2);
    blend_reg         = '0;
    alpha_reg         = 1'b1;
    clear_block();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_single_pixel();
    test_oversize_factor();
    test_block_restart();
    test_random_blocks();
    test_full_rate();
    test_output_stall();
    test_sender_pause();

    wait_drained();
    if (mismatch_count == 0) $display("block_downscale_center_blend regression: pass");
    else $display("block_downscale_center_blend regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
